// ----- sv/bbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared constants, types and coefficient tables of the band-pass envelope
// core.
// ----------------------------------------------------------------------------
package bbe_pkg;

  localparam int SECTIONS         = 4;
  localparam int TAPS             = 3 * SECTIONS + 3;
  localparam int ADDR_W           = $clog2(TAPS);
  localparam int SEC_W            = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int COEF_FRAC_BITS   = 12;
  localparam int DESIGN_FRAC_BITS = 12;
  localparam int COEF_W           = 14 + ((COEF_FRAC_BITS > DESIGN_FRAC_BITS) ?
                                          (COEF_FRAC_BITS - DESIGN_FRAC_BITS) : 0);
  localparam int DATA_W           = 32;
  localparam int PROD_W           = DATA_W + COEF_W;
  localparam int SAMPLE_W         = 12;
  localparam int SHIFT_W          = 4;
  localparam int OUT_W            = 25;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ADC_MIDPOINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_SHIFT    = 2'd2;

  localparam logic [SAMPLE_W-1:0] RESET_MIDPOINT  = 12'd2048;
  localparam logic [SHIFT_W-1:0]  RESET_OUT_SHIFT = 4'd7;
  localparam logic [SHIFT_W-1:0]  RESET_EMA_SHIFT = 4'd4;

  localparam logic [1:0] TERM_B2 = 2'd0;
  localparam logic [1:0] TERM_A2 = 2'd1;
  localparam logic [1:0] TERM_B1 = 2'd2;
  localparam logic [1:0] TERM_A1 = 2'd3;

  localparam int TAB_B2 [4] = '{4096, 4096, 4096, 4096};
  localparam int TAB_B1 [4] = '{-8110, -8171, -682, -5235};
  localparam int TAB_A2 [4] = '{3987, 3572, 3192, 3769};
  localparam int TAB_A1 [4] = '{-7928, -7404, -6426, -6265};

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [1:0]       term;
    logic [SEC_W-1:0] sec;
  } mac_op_t;

  typedef struct packed {
    logic              sec_done;
    logic [SEC_W-1:0]  sec;
    logic [DATA_W-1:0] acc;
  } mac_res_t;

  typedef struct packed {
    logic load;
    logic mag_en;
    logic out_en;
  } seq_stat_t;

  function automatic logic [ADDR_W-1:0] tap_offset(input logic [1:0] term);
    logic [ADDR_W-1:0] off;
    case (term)
      TERM_B2: off = ADDR_W'(2);
      TERM_A2: off = ADDR_W'(5);
      TERM_B1: off = ADDR_W'(1);
      default: off = ADDR_W'(4);
    endcase
    return off;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_value(input logic [SEC_W-1:0] sec,
                                                          input logic [1:0] term);
    int idx;
    int c;
    int dn;
    idx = int'(sec) & 3;
    case (term)
      TERM_B2: c = TAB_B2[idx];
      TERM_A2: c = TAB_A2[idx];
      TERM_B1: c = TAB_B1[idx];
      default: c = TAB_A1[idx];
    endcase
    if (COEF_FRAC_BITS >= DESIGN_FRAC_BITS) begin
      c = c <<< (COEF_FRAC_BITS - DESIGN_FRAC_BITS);
    end else begin
      dn = DESIGN_FRAC_BITS - COEF_FRAC_BITS;
      c = (c + (1 <<< (dn - 1))) >>> dn;
    end
    return COEF_W'(c);
  endfunction

endpackage

// ----- sv/bbe_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_sample_if
// Input channel carrying one raw ADC sample per item.
// ----------------------------------------------------------------------------
interface bbe_sample_if import bbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

// ----- sv/bbe_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_result_if
// Output channel carrying the band magnitude and envelope of one item.
// ----------------------------------------------------------------------------
interface bbe_result_if import bbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] band_magnitude;
  logic [OUT_W-1:0] envelope;

  modport source(output valid, output band_magnitude, output envelope, input ready);
  modport sink(input valid, input band_magnitude, input envelope, output ready);
endinterface

// ----- sv/bbe_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbe_cfg_if import bbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/bbe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bbe_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_mac
// Shared multiply-accumulate unit: one registered product per cycle and a
// 32-bit wrapping accumulator that flags the end of each section.
// ----------------------------------------------------------------------------
module bbe_mac import bbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [DATA_W-1:0] x,
  input  mac_op_t           op,
  input  logic [DATA_W-1:0] tap,
  output mac_res_t          res
);

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic [1:0]               p_term;
  logic [SEC_W-1:0]         p_sec;
  logic [DATA_W-1:0]        acc;
  logic                     done;
  logic [SEC_W-1:0]         done_sec;
  logic signed [DATA_W-1:0] tap_eff;
  logic signed [COEF_W-1:0] coef;
  logic [DATA_W-1:0]        term_val;
  logic                     p_sub;

  // Entries never written since reset read as zero.
  assign tap_eff  = op.hit ? $signed(tap) : '0;
  assign coef     = coef_value(op.sec, op.term);
  assign term_val = prod[COEF_FRAC_BITS +: DATA_W];
  assign p_sub    = (p_term == TERM_A2) || (p_term == TERM_A1);

  always_ff @(posedge clk) begin
    prod   <= PROD_W'(tap_eff) * PROD_W'(coef);
    p_term <= op.term;
    p_sec  <= op.sec;
    if (load) begin
      acc <= x;
    end else if (p_valid) begin
      acc <= p_sub ? (acc - term_val) : (acc + term_val);
    end
    done_sec <= p_sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= op.valid;
      done    <= p_valid && (p_term == TERM_A1);
    end
  end

  assign res.sec_done = done;
  assign res.sec      = done_sec;
  assign res.acc      = acc;

endmodule

// ----- sv/bbe_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_seq
// Sequencer and delay store: circular addressing of the tap RAM, fill bits,
// read issue for each product term and write-back of section outputs.
// ----------------------------------------------------------------------------
module bbe_seq import bbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] x,
  input  logic              out_free,
  input  mac_res_t          mac_res,
  output mac_op_t           op,
  output logic [DATA_W-1:0] tap,
  output seq_stat_t         stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MAG   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_new;
  logic [1:0]        term;
  logic [SEC_W-1:0]  sec;
  logic [ADDR_W-1:0] base;
  logic [TAPS-1:0]   filled;
  logic              accept;
  logic              issue;
  logic              last_issue;
  logic              last_done;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] wb_logical;

  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] p,
                                             input logic [ADDR_W-1:0] logical);
    logic [ADDR_W:0] sum;
    sum = {1'b0, p} + {1'b0, logical};
    if (sum >= (ADDR_W+1)'(TAPS)) begin
      sum = sum - (ADDR_W+1)'(TAPS);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign issue      = (state == ST_RUN);
  assign last_issue = issue && (term == TERM_A1) && (sec == SEC_W'(SECTIONS - 1));
  assign last_done  = mac_res.sec_done && (mac_res.sec == SEC_W'(SECTIONS - 1));

  // Moving the base pointer down by one shifts every tap up one place.
  assign ptr_new    = (ptr == '0) ? ADDR_W'(TAPS - 1) : (ptr - ADDR_W'(1));
  assign raddr      = phys(ptr, base + tap_offset(term));
  assign wb_logical = ADDR_W'((int'(mac_res.sec) + 1) * 3);

  always_comb begin
    we    = 1'b0;
    waddr = ptr_new;
    wdata = x;
    if (accept) begin
      we = 1'b1;
    end else if (mac_res.sec_done) begin
      we    = 1'b1;
      waddr = phys(ptr, wb_logical);
      wdata = mac_res.acc;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_RUN;
      ST_RUN:   if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (last_done) state_next = ST_MAG;
      ST_MAG:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op.hit  <= filled[raddr];
    op.term <= term;
    op.sec  <= sec;
    if (rst) begin
      state    <= ST_IDLE;
      ptr      <= '0;
      term     <= TERM_B2;
      sec      <= '0;
      base     <= '0;
      filled   <= '0;
      op.valid <= 1'b0;
    end else begin
      state    <= state_next;
      op.valid <= issue;
      if (accept) begin
        ptr  <= ptr_new;
        term <= TERM_B2;
        sec  <= '0;
        base <= '0;
      end else if (issue) begin
        term <= term + 2'd1;
        if (term == TERM_A1) begin
          sec  <= sec + SEC_W'(1);
          base <= base + ADDR_W'(3);
        end
      end
      if (we) begin
        filled[waddr] <= 1'b1;
      end
    end
  end

  bbe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TAPS)
  ) u_taps (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(tap)
  );

  assign stat.load   = accept;
  assign stat.mag_en = (state == ST_MAG);
  assign stat.out_en = (state == ST_OUT) && out_free;

endmodule

// ----- sv/biquad_bandpass_envelope_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_bandpass_envelope_core
// Biquad band-pass cascade on centered ADC samples, followed by magnitude
// and an exponential moving average envelope.
// ----------------------------------------------------------------------------
// Each item runs from acceptance through the multiply and accumulate pipeline
// and the magnitude and envelope steps to the result register, and a new item
// is accepted on the cycle after the previous one has reached the output
// register, so items do not overlap in the cascade. The item rate is set by the
// single shared multiplier and the one read port of the tap RAM, which deliver
// one product term per cycle, plus the multiply and accumulate pipeline and the
// magnitude and envelope steps. The result register holds a finished item while
// the next one is processed. The tap store starts out as all zero after reset
// without a clearing pass.
module biquad_bandpass_envelope_core import bbe_pkg::*; (
  input logic         clk,
  input logic         rst,
  bbe_cfg_if.sink     cfg,
  bbe_sample_if.sink  samples,
  bbe_result_if.source results
);

  localparam logic [DATA_W-1:0] OUT_MAX = DATA_W'((64'd1 << OUT_W) - 64'd1);

  logic [SAMPLE_W-1:0] adc_midpoint;
  logic [SHIFT_W-1:0]  out_shift;
  logic [SHIFT_W-1:0]  ema_shift;
  logic [DATA_W-1:0]   ema;
  logic [DATA_W-1:0]   band;
  logic                out_valid;
  logic [OUT_W-1:0]    band_out;
  logic [OUT_W-1:0]    env_out;

  logic signed [SAMPLE_W:0] centered;
  logic [DATA_W-1:0]        x;
  logic [DATA_W-1:0]        mag;
  logic [DATA_W-1:0]        ema_next;
  logic [DATA_W-1:0]        env_full;
  logic                     out_free;
  mac_op_t                  op;
  mac_res_t                 mac_res;
  seq_stat_t                stat;
  logic [DATA_W-1:0]        tap;

  function automatic logic [OUT_W-1:0] sat(input logic [DATA_W-1:0] v);
    return (v > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : v[OUT_W-1:0];
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_midpoint <= RESET_MIDPOINT;
      out_shift    <= RESET_OUT_SHIFT;
      ema_shift    <= RESET_EMA_SHIFT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ADC_MIDPOINT: adc_midpoint <= cfg.data[SAMPLE_W-1:0];
        REG_OUT_SHIFT:    out_shift    <= cfg.data[SHIFT_W-1:0];
        REG_EMA_SHIFT:    ema_shift    <= cfg.data[SHIFT_W-1:0];
        default:          ;
      endcase
    end
  end

  // The input scaling by 2^7/64 is exact and reduces to a doubling.
  assign centered = $signed({1'b0, samples.sample}) - $signed({1'b0, adc_midpoint});
  assign x        = DATA_W'($signed({centered, 1'b0}));

  assign out_free = !out_valid || results.ready;

  bbe_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .x       (x),
    .out_free(out_free),
    .mac_res (mac_res),
    .op      (op),
    .tap     (tap),
    .stat    (stat)
  );

  bbe_mac u_mac (
    .clk (clk),
    .rst (rst),
    .load(stat.load),
    .x   (x),
    .op  (op),
    .tap (tap),
    .res (mac_res)
  );

  assign mag      = mac_res.acc[DATA_W-1] ? (DATA_W'(0) - mac_res.acc) : mac_res.acc;
  assign ema_next = ema - (ema >> ema_shift) + band;
  assign env_full = ema_next >> ema_shift;

  always_ff @(posedge clk) begin
    if (stat.mag_en) begin
      band <= mag >> out_shift;
    end
    if (stat.out_en) begin
      band_out <= sat(band);
      env_out  <= sat(env_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ema       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stat.out_en) begin
        ema       <= ema_next;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.band_magnitude = band_out;
  assign results.envelope       = env_out;

endmodule
